>>> hdl/lru_cache_access_cost_assert.svh
// Assertion macros for the LRU cache access cost block.
// Included by the checker module; depends on nothing else.
`ifndef LRU_CACHE_ACCESS_COST_ASSERT_SVH
`define LRU_CACHE_ACCESS_COST_ASSERT_SVH

// Same-cycle implication, sampled on clock and idle during reset.
`define LCAC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and idle during reset.
`define LCAC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lcac_pkg.sv
// Shared types, constants and the key case-folding function.
// Used by the cache cells, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package lcac_pkg;

   // Counts of entries; seven bits count up to 127 entries.
   localparam int CNT_W = 7;
   localparam int KEY_W = 64;
   localparam int COST_W = 32;
   localparam int CAP_W = 6;

   localparam logic [COST_W-1:0] HIT_COST = 32'd1;
   localparam logic [COST_W-1:0] MISS_COST = 32'd5;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
   localparam logic [7:0] CASE_GAP = 8'd32;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_Z = 8'h7a;

   // Control that the top level hands to every cell in the row.
   typedef struct packed {
      logic             step;
      logic             store;
      logic [CNT_W-1:0] live;
      logic [CNT_W-1:0] keep;
   } cell_ctrl_type;

   // Fold every lower-case letter byte of a key to upper case.
   function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      logic [7:0]       b;
      r = k;
      for (int i = 0; i < KEY_W / 8; i++) begin
         b = k[i*8 +: 8];
         if (b >= LOWER_A && b <= LOWER_Z) begin
            r[i*8 +: 8] = b - CASE_GAP;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/lru_cache_access_cost.sv
// Top level of the LRU key cache with running access cost.
// Depends on lcac_pkg and on the lcac_cell row.
//
//   Channel   Ports                                   Direction
//   request   start, busy, req_key                    in (busy out)
//   response  rsp_valid, rsp_hit, rsp_total_cost      out, one-cycle strobe
//   csr       csr_valid, csr_ready, csr_capacity      in (ready out)
//
// A transaction is accepted every clock cycle while reset is not held; its response appears on the
// cycle after acceptance. The lookup, the move to front and the cost update
// all happen together across the cell row and its match chain.
// Synchronous reset clears occupancy and cost and sets capacity to 32; busy
// is high and csr_ready low while reset is held. Entry keys are not cleared.
// The receiver cannot stall, so no result is ever held back.
`timescale 1ns / 1ps
`default_nettype none

module lru_cache_access_cost
   import lcac_pkg::*;
#(
   parameter int ENTRIES = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [KEY_W-1:0]  req_key,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [COST_W-1:0]      rsp_total_cost,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CAP_W-1:0]  csr_capacity
);

   localparam logic [CNT_W-1:0] EntC = CNT_W'(ENTRIES);

   logic [CAP_W-1:0]  capacity_ff;
   logic [CNT_W-1:0]  occupancy_ff, occupancy_in;
   logic [COST_W-1:0] cost_ff, cost_in;
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;

   logic [KEY_W-1:0]  search_key;
   logic [CNT_W-1:0]  cap_ext, eff, live, keep;
   logic [COST_W-1:0] cost_inc;
   logic [COST_W:0]   cost_sum;
   cell_ctrl_type     ctrl;
   logic              lookup_hit;
   logic [ENTRIES:0]  match_w;
   logic [KEY_W-1:0]  key_w [ENTRIES];

   assign busy      = reset;
   assign csr_ready = ~reset;

   // Effective capacity, live entries and the number of entries kept on a miss.
   assign search_key = fold_key(req_key);
   assign cap_ext    = CNT_W'(capacity_ff);
   assign eff        = (cap_ext < EntC) ? cap_ext : EntC;
   assign live       = (occupancy_ff < eff) ? occupancy_ff : eff;
   assign keep       = (live < eff) ? live : eff - 1'b1;

   assign lookup_hit = match_w[0];
   assign ctrl.step  = start && !busy;
   assign ctrl.store = eff != '0;
   assign ctrl.live  = live;
   assign ctrl.keep  = keep;

   // Row of cells; the match chain runs from the back toward the front.
   assign match_w[ENTRIES] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [KEY_W-1:0] shift_key;
      if (i == 0) begin : g_front
         assign shift_key = search_key;
      end else begin : g_rest
         assign shift_key = key_w[i-1];
      end
      lcac_cell #(
         .IDX (i)
      ) u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .hit_any      (lookup_hit),
         .search_key   (search_key),
         .shift_key    (shift_key),
         .match_behind (match_w[i+1]),
         .match_out    (match_w[i]),
         .key_out      (key_w[i])
      );
   end

   // Occupancy after the access.
   always_comb begin
      if (lookup_hit) begin
         occupancy_in = live;
      end else if (ctrl.store) begin
         occupancy_in = keep + 1'b1;
      end else begin
         occupancy_in = '0;
      end
   end

   // Saturating cost update.
   assign cost_inc = lookup_hit ? HIT_COST : MISS_COST;
   assign cost_sum = {1'b0, cost_ff} + {1'b0, cost_inc};
   assign cost_in  = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

   // Control state, configuration and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         occupancy_ff <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
         rsp_valid_ff <= ctrl.step;
         if (ctrl.step) begin
            occupancy_ff <= occupancy_in;
            cost_ff      <= cost_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         rsp_hit_ff <= lookup_hit;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_total_cost = cost_ff;

endmodule

`default_nettype wire

>>> hdl/lcac_cell.sv
// One entry of the LRU row: holds a key, compares it and shifts toward the back.
// Depends on lcac_pkg for the control struct and widths.
`timescale 1ns / 1ps
`default_nettype none

module lcac_cell
   import lcac_pkg::*;
#(
   parameter int IDX = 0
) (
   input  wire logic             clock,
   input  wire cell_ctrl_type    ctrl,
   input  wire logic             hit_any,
   input  wire logic [KEY_W-1:0] search_key,
   input  wire logic [KEY_W-1:0] shift_key,
   input  wire logic             match_behind,
   output logic                  match_out,
   output logic [KEY_W-1:0]      key_out
);

   localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

   logic [KEY_W-1:0] key_ff;
   logic             live_here;
   logic             match_here;
   logic             load;

   // The entry only counts while it lies inside the live part of the row.
   assign live_here  = IdxC < ctrl.live;
   assign match_here = live_here && (key_ff == search_key);
   assign match_out  = match_here | match_behind;
   assign key_out    = key_ff;

   // On a hit every entry up to the matching one moves back; on a miss the
   // kept entries move back to make room at the front.
   assign load = ctrl.step && (hit_any ? match_out : (ctrl.store && IdxC <= ctrl.keep));

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff <= shift_key;
      end
   end

endmodule

`default_nettype wire

>>> hdl/lcac_checker.sv
// Port-level checker for the LRU cache access cost block, bound to the top.
// Depends on lcac_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "lru_cache_access_cost_assert.svh"

module lcac_checker
   import lcac_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire logic              rsp_hit,
   input wire logic [COST_W-1:0] rsp_total_cost
);

   logic [COST_W-1:0] last_cost_ff;
   logic              seen_ff;
   logic [COST_W:0]   exp_sum;
   logic [COST_W-1:0] exp_cost;

   // Track the cost of the last response since reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_cost_ff <= '0;
         seen_ff      <= 1'b0;
      end else if (rsp_valid) begin
         last_cost_ff <= rsp_total_cost;
         seen_ff      <= 1'b1;
      end
   end

   assign exp_sum  = {1'b0, last_cost_ff} + {1'b0, (rsp_hit ? HIT_COST : MISS_COST)};
   assign exp_cost = exp_sum[COST_W] ? '1 : exp_sum[COST_W-1:0];

   `LCAC_ASSERT_NEXT(a_rsp_follows, start && !busy, rsp_valid, "response missing after transaction")
   `LCAC_ASSERT_NEXT(a_no_spurious, !(start && !busy), !rsp_valid, "response without transaction")
   `LCAC_ASSERT_IMPL(a_cost_step, rsp_valid, rsp_total_cost == exp_cost, "cost step is wrong")
   `LCAC_ASSERT_IMPL(a_first_miss, rsp_valid && !seen_ff, !rsp_hit, "hit on an empty cache")

endmodule

bind lru_cache_access_cost lcac_checker u_lcac_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_hit        (rsp_hit),
   .rsp_total_cost (rsp_total_cost)
);

`default_nettype wire
